// ===== rtl/nx_ls_pkg.sv =====
// Package for the Nx length statistic block: field widths, command codes,
// cell operation codes and the bus struct passed between neighboring cells.
// No dependencies; every other file refers to it by scoped names.
package nx_ls_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);

    localparam int CMD_W = 2;
    localparam int LEN_W = 32;
    localparam int PCT_W = 7;
    localparam int TOT_W = 40;

    // Divide by 100 for the percent limits
    localparam int PCT_DIVISOR = 100;
    localparam int REM_W       = $clog2(PCT_DIVISOR);
    // Divider takes one byte of the total per step
    localparam int DIV_CHUNK_W = 8;
    localparam int DIV_STEPS   = TOT_W / DIV_CHUNK_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int DIV_PART_W  = REM_W + DIV_CHUNK_W;
    // ceil(2^22 / 100): floor(v * DIV_RECIP / 2^22) == v / 100 for any 15-bit v
    localparam int DIV_RECIP   = 41944;
    localparam int DIV_RECIP_W = 16;
    localparam int DIV_SHIFT   = 22;
    // 100 > 2^6, so the quotient loses six bits
    localparam int QUO_W       = TOT_W - 6;
    localparam int LIM_W       = QUO_W + PCT_W;
    // Sum of every held length never wraps at this width
    localparam int SUM_W       = LEN_W + IDX_W;
    localparam int CMP_W       = (LIM_W > SUM_W) ? LIM_W : SUM_W;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef logic [1:0] t_cell_op;
    localparam t_cell_op OP_HOLD   = 2'd0;
    localparam t_cell_op OP_INSERT = 2'd1;
    localparam t_cell_op OP_ROTATE = 2'd2;
    localparam t_cell_op OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             occ;
        logic             shift;   // cell gives way to the length being inserted
    } t_cell_bus;

endpackage

// ===== rtl/nx_ls_in_if.sv =====
// Input channel of the Nx length statistic block: valid/ready plus one command item.
// Depends on nx_ls_pkg.
interface nx_ls_in_if;
    logic                         valid;
    logic                         ready;
    logic [nx_ls_pkg::CMD_W-1:0]  command;
    logic [nx_ls_pkg::LEN_W-1:0]  length;
    logic [nx_ls_pkg::PCT_W-1:0]  percent;

    modport source (output valid, output command, output length, output percent,
                    input ready);
    modport sink   (input valid, input command, input length, input percent,
                    output ready);
endinterface

// ===== rtl/nx_ls_out_if.sv =====
// Result channel of the Nx length statistic block: valid/ready plus one answer item.
// Depends on nx_ls_pkg.
interface nx_ls_out_if;
    logic                         valid;
    logic                         ready;
    logic [nx_ls_pkg::PCT_W-1:0]  percent_echo;
    logic [nx_ls_pkg::LEN_W-1:0]  nx_length;
    logic                         valid_res;
    logic                         dropped;

    modport source (output valid, output percent_echo, output nx_length,
                    output valid_res, output dropped, input ready);
    modport sink   (input valid, input percent_echo, input nx_length,
                    input valid_res, input dropped, output ready);
endinterface

// ===== rtl/nx_length_statistic_top.sv =====
// Top level of the Nx length statistic block: sorted cell chain, divider and query control.
// Depends on nx_ls_pkg, nx_ls_in_if, nx_ls_out_if, nx_ls_cell and nx_ls_div100.
//
// Usage:
//   i_in carries command items (load a length, query a percentile, clear the list).
//   o_out carries one answer item per query; loads and clears give none.
//   i_cfg_we / i_cfg_data write the 40-bit genome total used for percent limits.
// Sequence:
//   A load or clear keeps input ready; the next item can follow at once.
//   A query runs 5 divider steps for total/100 (one byte per step), one multiply
//   by the percent, then the whole cell chain rotates once past the accumulator
//   so contents come back in order.
//   Input is held off (ready low) while a query is in progress.
// Reset clears the list, the drop flag, the total and any pending answer.
// A stalled receiver holds the answer in the output register; further loads and
// clears are still taken, and the next query waits only at its final step.
module nx_length_statistic_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [nx_ls_pkg::TOT_W-1:0]  i_cfg_data,
    nx_ls_in_if.sink                     i_in,
    nx_ls_out_if.source                  o_out
);

    localparam int                 MAX_ENTRIES = nx_ls_pkg::MAX_ENTRIES;
    localparam int                 IDX_W       = nx_ls_pkg::IDX_W;
    localparam logic [IDX_W-1:0]   LAST_CELL   = IDX_W'(MAX_ENTRIES - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]                         r_state;
    logic [nx_ls_pkg::TOT_W-1:0]        r_total_length;
    logic                               r_overflow;
    logic [nx_ls_pkg::PCT_W-1:0]        r_percent;
    logic [nx_ls_pkg::LIM_W-1:0]        r_limit;
    logic [nx_ls_pkg::SUM_W-1:0]        r_sum;
    logic [nx_ls_pkg::LEN_W-1:0]        r_ans;
    logic                               r_ans_vld;
    logic                               r_walk_done;
    logic [IDX_W-1:0]                   r_walk_cnt;

    logic                               r_out_valid;
    logic [nx_ls_pkg::PCT_W-1:0]        r_out_pct;
    logic [nx_ls_pkg::LEN_W-1:0]        r_out_len;
    logic                               r_out_vres;
    logic                               r_out_drop;

    logic                               w_in_acc;
    logic                               w_out_acc;
    logic                               w_full;
    logic                               w_div_start;
    logic                               w_div_done;
    logic [nx_ls_pkg::QUO_W-1:0]        w_quo;
    logic [nx_ls_pkg::SUM_W-1:0]        n_sum;
    logic                               w_out_free;
    nx_ls_pkg::t_cell_op                w_op;
    nx_ls_pkg::t_cell_bus               w_bus  [MAX_ENTRIES];
    nx_ls_pkg::t_cell_bus               w_prev [MAX_ENTRIES];
    nx_ls_pkg::t_cell_bus               w_next [MAX_ENTRIES];

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_out_acc   = r_out_valid && o_out.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_full      = w_bus[MAX_ENTRIES-1].occ;
    assign w_div_start = w_in_acc && (i_in.command == nx_ls_pkg::CMD_QUERY);
    assign n_sum       = r_sum + nx_ls_pkg::SUM_W'(w_bus[0].len);

    assign o_out.valid        = r_out_valid;
    assign o_out.percent_echo = r_out_pct;
    assign o_out.nx_length    = r_out_len;
    assign o_out.valid_res    = r_out_vres;
    assign o_out.dropped      = r_out_drop;

    always_comb begin
        w_op = nx_ls_pkg::OP_HOLD;
        if (r_state == ST_WALK) begin
            w_op = nx_ls_pkg::OP_ROTATE;
        end else if (w_in_acc) begin
            case (i_in.command)
                nx_ls_pkg::CMD_LOAD: begin
                    if (!w_full) begin
                        w_op = nx_ls_pkg::OP_INSERT;
                    end
                end
                nx_ls_pkg::CMD_CLEAR: begin
                    w_op = nx_ls_pkg::OP_CLEAR;
                end
                default: begin
                    w_op = nx_ls_pkg::OP_HOLD;
                end
            endcase
        end
    end

    // Cell chain; the last cell wraps to the first for the query rotation
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev[g] = '0;
        end else begin : g_body
            assign w_prev[g] = w_bus[g-1];
        end
        assign w_next[g] = w_bus[(g + 1) % MAX_ENTRIES];

        nx_ls_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op),
            .i_len   (i_in.length),
            .i_prev  (w_prev[g]),
            .i_next  (w_next[g]),
            .o_bus   (w_bus[g])
        );
    end

    nx_ls_div100 u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_total_length),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_total_length <= '0;
            r_overflow     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_total_length <= i_cfg_data;
            end
            if ((r_state == ST_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        case (i_in.command)
                            nx_ls_pkg::CMD_LOAD: begin
                                if (w_full) begin
                                    r_overflow <= 1'b1;
                                end
                            end
                            nx_ls_pkg::CMD_QUERY: begin
                                r_state <= ST_DIV;
                            end
                            nx_ls_pkg::CMD_CLEAR: begin
                                r_overflow <= 1'b0;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_WALK;
                end
                ST_WALK: begin
                    if (r_walk_cnt == LAST_CELL) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Query datapath; cell 0 passes the accumulator once per rotation step
    always_ff @(posedge i_clk) begin
        if (w_div_start) begin
            r_percent <= i_in.percent;
        end
        if (r_state == ST_MUL) begin
            r_limit     <= nx_ls_pkg::LIM_W'(w_quo) * nx_ls_pkg::LIM_W'(r_percent);
            r_sum       <= '0;
            r_ans       <= '0;
            r_ans_vld   <= 1'b0;
            r_walk_done <= 1'b0;
            r_walk_cnt  <= '0;
        end
        if (r_state == ST_WALK) begin
            r_walk_cnt <= r_walk_cnt + 1'b1;
            if (!r_walk_done) begin
                if (w_bus[0].occ) begin
                    r_sum     <= n_sum;
                    r_ans     <= w_bus[0].len;
                    r_ans_vld <= 1'b1;
                    if (nx_ls_pkg::CMP_W'(n_sum) >= nx_ls_pkg::CMP_W'(r_limit)) begin
                        r_walk_done <= 1'b1;
                    end
                end else begin
                    r_walk_done <= 1'b1;
                end
            end
        end
        if ((r_state == ST_OUT) && w_out_free) begin
            r_out_pct  <= r_percent;
            r_out_len  <= r_ans;
            r_out_vres <= r_ans_vld;
            r_out_drop <= r_overflow;
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.command == nx_ls_pkg::CMD_CLEAR)) |=> !w_bus[0].occ)
        else $error("list not empty after clear");

    a_load_fills_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.command == nx_ls_pkg::CMD_LOAD)) |=> w_bus[0].occ)
        else $error("head cell empty after load");

    a_prefix_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_WALK) |-> (!w_bus[1].occ || w_bus[0].occ))
        else $error("occupied cells not contiguous from the head");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside a query");

    a_answer_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("answer raised outside the output step");
`endif

endmodule

// ===== rtl/nx_ls_cell.sv =====
// One cell of the sorted length chain: holds one length and its occupied bit.
// Depends on nx_ls_pkg.
module nx_ls_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  nx_ls_pkg::t_cell_op          i_op,
    input  logic [nx_ls_pkg::LEN_W-1:0]  i_len,
    input  nx_ls_pkg::t_cell_bus         i_prev,
    input  nx_ls_pkg::t_cell_bus         i_next,
    output nx_ls_pkg::t_cell_bus         o_bus
);

    logic [nx_ls_pkg::LEN_W-1:0] r_len;
    logic                        r_occ;
    logic                        w_shift;

    // Equal lengths stay put, so a new one lands behind them
    assign w_shift = !r_occ || (r_len < i_len);

    assign o_bus.len   = r_len;
    assign o_bus.occ   = r_occ;
    assign o_bus.shift = w_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            case (i_op)
                nx_ls_pkg::OP_INSERT: begin
                    if (w_shift) begin
                        r_occ <= i_prev.shift ? i_prev.occ : 1'b1;
                    end
                end
                nx_ls_pkg::OP_ROTATE: begin
                    r_occ <= i_next.occ;
                end
                nx_ls_pkg::OP_CLEAR: begin
                    r_occ <= 1'b0;
                end
                default: begin
                    r_occ <= r_occ;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            nx_ls_pkg::OP_INSERT: begin
                if (w_shift) begin
                    r_len <= i_prev.shift ? i_prev.len : i_len;
                end
            end
            nx_ls_pkg::OP_ROTATE: begin
                r_len <= i_next.len;
            end
            default: begin
                r_len <= r_len;
            end
        endcase
    end

endmodule

// ===== rtl/nx_ls_div100.sv =====
// Divider by 100: one byte of the dividend per cycle through a reciprocal multiply.
// Depends on nx_ls_pkg.
module nx_ls_div100 (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [nx_ls_pkg::TOT_W-1:0]  i_dividend,
    output logic                         o_done,
    output logic [nx_ls_pkg::QUO_W-1:0]  o_quotient
);

    localparam int PROD_W = nx_ls_pkg::DIV_PART_W + nx_ls_pkg::DIV_RECIP_W;
    localparam logic [nx_ls_pkg::REM_W-1:0] DIVISOR =
        nx_ls_pkg::REM_W'(nx_ls_pkg::PCT_DIVISOR);
    localparam logic [nx_ls_pkg::DIV_RECIP_W-1:0] RECIP =
        nx_ls_pkg::DIV_RECIP_W'(nx_ls_pkg::DIV_RECIP);
    localparam logic [nx_ls_pkg::DIV_CNT_W-1:0] LAST_STEP =
        nx_ls_pkg::DIV_CNT_W'(nx_ls_pkg::DIV_STEPS - 1);

    logic                              r_busy;
    logic                              r_done;
    logic [nx_ls_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [nx_ls_pkg::REM_W-1:0]       r_rem;
    // Dividend bytes shift out at the top while quotient bytes enter at the bottom
    logic [nx_ls_pkg::TOT_W-1:0]       r_quo;
    logic [nx_ls_pkg::DIV_PART_W-1:0]  w_part;
    logic [PROD_W-1:0]                 w_prod;
    logic [nx_ls_pkg::DIV_CHUNK_W-1:0] w_digit;
    logic [nx_ls_pkg::DIV_PART_W-1:0]  w_back;
    logic [nx_ls_pkg::DIV_PART_W-1:0]  w_left;

    // Remainder so far joined with the next byte; stays below 100 * 256
    assign w_part     = {r_rem, r_quo[nx_ls_pkg::TOT_W-1 -: nx_ls_pkg::DIV_CHUNK_W]};
    assign w_prod     = PROD_W'(w_part) * PROD_W'(RECIP);
    assign w_digit    = w_prod[nx_ls_pkg::DIV_SHIFT +: nx_ls_pkg::DIV_CHUNK_W];
    assign w_back     = nx_ls_pkg::DIV_PART_W'(w_digit) * nx_ls_pkg::DIV_PART_W'(DIVISOR);
    assign w_left     = w_part - w_back;
    assign o_done     = r_done;
    assign o_quotient = r_quo[nx_ls_pkg::QUO_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_left[nx_ls_pkg::REM_W-1:0];
            r_quo <= {r_quo[nx_ls_pkg::TOT_W-nx_ls_pkg::DIV_CHUNK_W-1:0], w_digit};
        end
    end

endmodule

// ===== tb/nx_length_statistic_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for nx_length_statistic_top: drives load/query/clear items,
// predicts each percentile answer from a sorted shadow list, checks the answer channel.
// Depends on nx_ls_pkg, nx_ls_in_if, nx_ls_out_if and the top-level RTL.
module nx_length_statistic_top_tb;

    localparam logic [nx_ls_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int ITEM_GOAL     = 650;
    localparam int BACKLOG_DEPTH = 4;
    // Quiet stretch before a total write and before the end of the run
    localparam int SETTLE_CYCLES = nx_ls_pkg::MAX_ENTRIES + 64;
    // Longest quiet stretch: a full query, a long output stall, then a settle pause
    localparam int STALL_LIMIT   = 8 * (nx_ls_pkg::MAX_ENTRIES + 100);

    typedef struct {
        logic [nx_ls_pkg::CMD_W-1:0] cmd;
        logic [nx_ls_pkg::LEN_W-1:0] len;
        logic [nx_ls_pkg::PCT_W-1:0] pct;
    } t_cmd_item;

    typedef struct {
        logic [nx_ls_pkg::PCT_W-1:0] pct;
        logic [nx_ls_pkg::LEN_W-1:0] nx;
        logic                        ok;
        logic                        drop;
    } t_answer;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                        drv_valid = 1'b0;
    logic [nx_ls_pkg::CMD_W-1:0] drv_cmd   = '0;
    logic [nx_ls_pkg::LEN_W-1:0] drv_len   = '0;
    logic [nx_ls_pkg::PCT_W-1:0] drv_pct   = '0;
    logic                        rcv_ready = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic [nx_ls_pkg::TOT_W-1:0] cfg_data  = '0;

    nx_ls_in_if  cmd_if();
    nx_ls_out_if ans_if();

    assign cmd_if.valid   = drv_valid;
    assign cmd_if.command = drv_cmd;
    assign cmd_if.length  = drv_len;
    assign cmd_if.percent = drv_pct;
    assign ans_if.ready   = rcv_ready;

    nx_length_statistic_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (cmd_if),
        .o_out      (ans_if)
    );

    // Shadow of the sorted list, largest first
    logic [nx_ls_pkg::LEN_W-1:0] ranked_len [nx_ls_pkg::MAX_ENTRIES];
    int unsigned                 ranked_cnt = 0;
    logic                        drop_seen = 1'b0;
    logic [nx_ls_pkg::TOT_W-1:0] genome_total = '0;
    longint unsigned             held_sum = 0;

    t_cmd_item cmd_backlog [$];
    t_answer   answers_due [$];
    t_cmd_item next_cmd;
    t_answer   oldest;

    int  items_sent   = 0;
    int  mismatches   = 0;
    int  stall_cycles = 0;
    int  tx_gap       = 0;
    int  rcv_hold     = 0;
    bit  tx_calm      = 1'b0;
    bit  rx_calm      = 1'b0;
    bit  cmd_taken    = 1'b0;

    initial forever #5 i_clk = ~i_clk;

    function automatic void apply_command(logic [nx_ls_pkg::CMD_W-1:0] cmd,
                                          logic [nx_ls_pkg::LEN_W-1:0] len,
                                          logic [nx_ls_pkg::PCT_W-1:0] pct);
        int unsigned     pos;
        int unsigned     k;
        longint unsigned limit;
        longint unsigned acc;
        t_answer         ans;
        case (cmd)
            nx_ls_pkg::CMD_LOAD: begin
                if (ranked_cnt >= nx_ls_pkg::MAX_ENTRIES) begin
                    drop_seen = 1'b1;
                end else begin
                    // equal lengths keep arrival order
                    pos = 0;
                    while (pos < ranked_cnt && ranked_len[pos] >= len)
                        pos++;
                    for (k = ranked_cnt; k > pos; k--)
                        ranked_len[k] = ranked_len[k - 1];
                    ranked_len[pos] = len;
                    ranked_cnt++;
                    held_sum += len;
                end
            end
            nx_ls_pkg::CMD_CLEAR: begin
                ranked_cnt = 0;
                held_sum   = 0;
                drop_seen  = 1'b0;
            end
            nx_ls_pkg::CMD_QUERY: begin
                ans.pct  = pct;
                ans.nx   = '0;
                ans.ok   = 1'b0;
                ans.drop = drop_seen;
                if (ranked_cnt > 0) begin
                    ans.ok = 1'b1;
                    limit  = genome_total;
                    limit  = (limit / nx_ls_pkg::PCT_DIVISOR) * pct;
                    if (limit == 0) begin
                        ans.nx = ranked_len[0];
                    end else begin
                        acc = 0;
                        k   = 0;
                        while (acc < limit && k < ranked_cnt) begin
                            acc += ranked_len[k];
                            k++;
                        end
                        ans.nx = ranked_len[k - 1];
                    end
                end
                answers_due.push_back(ans);
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(12, 40);
    endfunction

    function automatic logic [nx_ls_pkg::LEN_W-1:0] rand_length();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 255);
            2: return 32'd1000 << $urandom_range(0, 3);
            3: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return $urandom_range(1000, 5000000);
        endcase
    endfunction

    function automatic logic [nx_ls_pkg::PCT_W-1:0] rand_percent();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return nx_ls_pkg::PCT_W'($urandom_range(1, 99));
        else if (r < 88)
            return nx_ls_pkg::PCT_W'($urandom_range(100, 127));
        else if (r < 94)
            return '0;
        else
            return nx_ls_pkg::PCT_W'($urandom_range(0, 127));
    endfunction

    // Mostly a total near the held sum so percentiles land inside the list
    function automatic logic [nx_ls_pkg::TOT_W-1:0] choose_total();
        longint unsigned scaled;
        logic [7:0]      top;
        top    = 8'($urandom);
        scaled = held_sum;
        if (scaled == 0)
            scaled = $urandom_range(1, 1000000);
        scaled = scaled / nx_ls_pkg::PCT_DIVISOR * $urandom_range(60, 180);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return {top, $urandom};
            default: return (scaled > 40'hFF_FFFF_FFFF) ? '1 : scaled[nx_ls_pkg::TOT_W-1:0];
        endcase
    endfunction

    task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
        mismatches++;
        $display("%0t mismatch: %s expected %0h got %0h", $time, what, want, got);
    endtask

    task automatic push_cmd(logic [nx_ls_pkg::CMD_W-1:0] cmd,
                            logic [nx_ls_pkg::LEN_W-1:0] len,
                            logic [nx_ls_pkg::PCT_W-1:0] pct);
        t_cmd_item it;
        while (cmd_backlog.size() >= BACKLOG_DEPTH)
            @(posedge i_clk);
        it.cmd = cmd;
        it.len = len;
        it.pct = pct;
        cmd_backlog.push_back(it);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic push_random();
        int r;
        r = $urandom_range(0, 99);
        if (r < 64)
            push_cmd(nx_ls_pkg::CMD_LOAD, rand_length(), rand_percent());
        else if (r < 90)
            push_cmd(nx_ls_pkg::CMD_QUERY, $urandom, rand_percent());
        else if (r < 94)
            push_cmd(CMD_UNUSED, $urandom, nx_ls_pkg::PCT_W'($urandom_range(0, 127)));
        else
            push_cmd(nx_ls_pkg::CMD_CLEAR, $urandom, rand_percent());
    endtask

    task automatic drain();
        while (cmd_backlog.size() != 0 || drv_valid || answers_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_total(logic [nx_ls_pkg::TOT_W-1:0] value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        genome_total = value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Sender: next item once the current one is taken, after its gap
    always @(negedge i_clk) begin
        if (!drv_valid || cmd_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                drv_valid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
                next_cmd = cmd_backlog.pop_front();
                drv_cmd   <= next_cmd.cmd;
                drv_len   <= next_cmd.len;
                drv_pct   <= next_cmd.pct;
                drv_valid <= 1'b1;
                tx_gap = pick_gap(tx_calm);
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Receiver stalls
    always @(negedge i_clk) begin
        if (rcv_hold > 0)
            rcv_hold--;
        else
            rcv_hold = pick_gap(rx_calm);
        rcv_ready <= (rcv_hold == 0);
    end

    // Monitor: check answers against the oldest outstanding prediction, then predict
    always @(posedge i_clk) begin
        cmd_taken = i_rst_n && cmd_if.valid && cmd_if.ready;
        if (i_rst_n && ans_if.valid && ans_if.ready) begin
            if (answers_due.size() == 0) begin
                report_mismatch("answer with no query outstanding, nx_length", 0,
                                ans_if.nx_length);
            end else begin
                oldest = answers_due.pop_front();
                if (ans_if.percent_echo !== oldest.pct)
                    report_mismatch("percent_echo", oldest.pct, ans_if.percent_echo);
                if (ans_if.nx_length !== oldest.nx)
                    report_mismatch("nx_length", oldest.nx, ans_if.nx_length);
                if (ans_if.valid_res !== oldest.ok)
                    report_mismatch("valid_res", oldest.ok, ans_if.valid_res);
                if (ans_if.dropped !== oldest.drop)
                    report_mismatch("dropped", oldest.drop, ans_if.dropped);
            end
        end
        if (cmd_taken)
            apply_command(cmd_if.command, cmd_if.length, cmd_if.percent);
    end

    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (ans_if.valid && ans_if.ready) || cfg_we)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int n;
        int seg;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty list, ignored command, extreme and equal lengths, zero limit
        write_total('0);
        push_cmd(nx_ls_pkg::CMD_QUERY, '0, 7'd50);
        push_cmd(CMD_UNUSED, $urandom, nx_ls_pkg::PCT_W'($urandom_range(0, 127)));
        push_cmd(nx_ls_pkg::CMD_LOAD, 32'd0, '0);
        push_cmd(nx_ls_pkg::CMD_LOAD, 32'hFFFF_FFFF, '0);
        push_cmd(nx_ls_pkg::CMD_LOAD, 32'd100, '0);
        push_cmd(nx_ls_pkg::CMD_LOAD, 32'd100, '0);
        push_cmd(nx_ls_pkg::CMD_LOAD, 32'd1, '0);
        push_cmd(nx_ls_pkg::CMD_LOAD, 32'd100, '0);
        push_cmd(nx_ls_pkg::CMD_QUERY, '0, 7'd0);
        push_cmd(nx_ls_pkg::CMD_QUERY, '0, 7'd127);
        write_total('1);
        // limit past the whole sum for any nonzero percent: smallest length held; zero gives the largest
        push_cmd(nx_ls_pkg::CMD_QUERY, '0, 7'd1);
        push_cmd(nx_ls_pkg::CMD_QUERY, '0, 7'd99);
        push_cmd(nx_ls_pkg::CMD_QUERY, '0, 7'd127);
        push_cmd(nx_ls_pkg::CMD_QUERY, '0, 7'd0);
        write_total(nx_ls_pkg::TOT_W'(held_sum * 2));
        push_cmd(nx_ls_pkg::CMD_QUERY, '0, 7'd25);
        push_cmd(nx_ls_pkg::CMD_QUERY, '0, 7'd50);
        push_cmd(nx_ls_pkg::CMD_QUERY, '0, 7'd51);
        push_cmd(nx_ls_pkg::CMD_CLEAR, '0, '0);
        push_cmd(nx_ls_pkg::CMD_QUERY, '0, 7'd33);

        seg = 0;
        while (items_sent < ITEM_GOAL) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if (seg == 2) begin
                // Fill past capacity so loads get dropped
                push_cmd(nx_ls_pkg::CMD_CLEAR, '0, '0);
                for (n = 0; n < nx_ls_pkg::MAX_ENTRIES + 12; n++) begin
                    push_cmd(nx_ls_pkg::CMD_LOAD, rand_length(), rand_percent());
                    if ($urandom_range(0, 19) == 0)
                        push_cmd(nx_ls_pkg::CMD_QUERY, '0, rand_percent());
                end
                write_total(choose_total());
                for (n = 0; n < 6; n++)
                    push_cmd(nx_ls_pkg::CMD_QUERY, '0, rand_percent());
            end else begin
                if ($urandom_range(0, 2) == 0)
                    push_cmd(nx_ls_pkg::CMD_CLEAR, $urandom, rand_percent());
                n = $urandom_range(6, 30);
                repeat (n) push_random();
                write_total(choose_total());
                n = $urandom_range(4, 16);
                repeat (n) begin
                    if ($urandom_range(0, 9) < 6)
                        push_cmd(nx_ls_pkg::CMD_QUERY, $urandom, rand_percent());
                    else
                        push_random();
                    if ($urandom_range(0, 9) == 0)
                        drain();
                end
            end
            seg++;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== nx_length_statistic_top.f =====
rtl/nx_ls_pkg.sv
rtl/nx_ls_in_if.sv
rtl/nx_ls_out_if.sv
rtl/nx_ls_cell.sv
rtl/nx_ls_div100.sv
rtl/nx_length_statistic_top.sv
tb/nx_length_statistic_top_tb.sv
